// ===== rtl/b64e_pkg.sv =====
// Package for the Base64 encoder with line wrapping.
// Holds the character constants, the job record passed from front to back,
// and the alphabet lookup. No dependencies.
package b64e_pkg;

  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned LINE_W       = 10;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned JOB_CHARS    = 6;
  localparam int unsigned IDX_W        = 3;

  localparam logic [LINE_W-1:0] MAX_LINE_RESET = 10'd76;

  localparam logic [CHAR_W-1:0] CHAR_CR  = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_PAD = 8'h3D;

  // index of the last character of a job
  localparam logic [IDX_W-1:0] LAST_PLAIN = 3'd3;
  localparam logic [IDX_W-1:0] LAST_CRLF  = 3'd5;

  typedef struct packed {
    logic [JOB_CHARS-1:0][CHAR_W-1:0] chars;
    logic                             crlf;
    logic                             msg_end;
  } job_t;

  function automatic logic [CHAR_W-1:0] sym(input logic [5:0] six);
    logic [CHAR_W-1:0] v;
    v = {2'b00, six};
    if (six < 6'd26)      sym = 8'h41 + v;
    else if (six < 6'd52) sym = 8'h61 + (v - 8'd26);
    else if (six < 6'd62) sym = 8'h30 + (v - 8'd52);
    else if (six == 6'd62) sym = 8'h2B;
    else                  sym = 8'h2F;
  endfunction

endpackage

// ===== rtl/base64_encoder_line_wrap.sv =====
// Base64 encoder with CR LF line wrapping: top level.
// Instantiates b64e_front, b64e_queue and b64e_back; uses b64e_pkg.
//
// Usage:
//   in_*  : one message byte per request, in_tlast marks the final byte.
//   out_* : one ASCII character per request; out_tlast marks the last
//           character caused by an input byte, out_tuser the last character
//           of the encoded message.
//   cfg_* : writes max_line_length; always ready. Write only while idle.
// Every third byte (or a final byte) queues a job of 4 characters, or 6
// when CR LF follows. The back end drains one character per cycle while
// out_tready allows, limited by the single-character output register.
// The first character of a group goes through the queue write and then
// the output register before it becomes valid.
// When the receiver stalls, the output holds, the job queue fills and
// in_tready drops once QUEUE_DEPTH jobs wait.
// Reset (rst_n low, synchronous) clears group, line count and queue, and
// sets max_line_length to 76.
module base64_encoder_line_wrap #(
  parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] data_byte
  input  logic                          in_tlast,   // final_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [7:0] out_char
  output logic                          out_tlast,  // run_last
  output logic                          out_tuser,  // [0] message_end
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [b64e_pkg::LINE_W-1:0]   cfg_data
);

  b64e_pkg::job_t  push_job, head_job;
  logic            q_push, q_pop, q_full, q_empty;

  b64e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (head_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== rtl/b64e_front.sv =====
// Front end: accepts bytes, gathers 3-byte groups, tracks line length and
// builds character jobs for the queue. Depends on b64e_pkg.
module b64e_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,
  input  logic                          in_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [b64e_pkg::LINE_W-1:0]   cfg_data,
  input  logic                          q_full,
  output logic                          q_push,
  output b64e_pkg::job_t                q_job
);

  logic [1:0]                   pos_r, pos_nxt;
  logic [15:0]                  pend_r, pend_nxt;
  logic [b64e_pkg::LINE_W-1:0]  len_r, len_nxt;
  logic [b64e_pkg::LINE_W-1:0]  max_len_r;

  logic                         accept;
  logic [1:0]                   pos;
  logic                         emit;
  logic                         wrap;
  logic [7:0]                   b, c1, c2;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  assign b    = in_tdata;
  assign c1   = pend_r[15:8];
  assign c2   = pend_r[7:0];
  assign pos  = (pos_r == 2'd3) ? 2'd0 : pos_r;
  assign emit = in_tlast || (pos == 2'd2);
  assign wrap = ({1'b0, len_r} + 11'd8) > {1'b0, max_len_r};

  always_comb begin
    pos_nxt  = pos_r;
    pend_nxt = pend_r;
    len_nxt  = len_r;
    q_job    = '0;
    q_push   = accept && emit;
    unique case (pos)
      2'd0: begin
        q_job.chars[0] = b64e_pkg::sym(b[7:2]);
        q_job.chars[1] = b64e_pkg::sym({b[1:0], 4'b0000});
        q_job.chars[2] = b64e_pkg::CHAR_PAD;
        q_job.chars[3] = b64e_pkg::CHAR_PAD;
      end
      2'd1: begin
        q_job.chars[0] = b64e_pkg::sym(c1[7:2]);
        q_job.chars[1] = b64e_pkg::sym({c1[1:0], b[7:4]});
        q_job.chars[2] = b64e_pkg::sym({b[3:0], 2'b00});
        q_job.chars[3] = b64e_pkg::CHAR_PAD;
      end
      default: begin
        q_job.chars[0] = b64e_pkg::sym(c1[7:2]);
        q_job.chars[1] = b64e_pkg::sym({c1[1:0], c2[7:4]});
        q_job.chars[2] = b64e_pkg::sym({c2[3:0], b[7:6]});
        q_job.chars[3] = b64e_pkg::sym(b[5:0]);
        q_job.chars[4] = b64e_pkg::CHAR_CR;
        q_job.chars[5] = b64e_pkg::CHAR_LF;
        q_job.crlf     = wrap;
      end
    endcase
    q_job.msg_end = in_tlast;

    if (accept) begin
      if (!emit) begin
        if (pos == 2'd0) pend_nxt = {b, 8'h00};
        else             pend_nxt = {c1, b};
        pos_nxt = pos + 2'd1;
      end else begin
        pos_nxt  = 2'd0;
        pend_nxt = '0;
        if (in_tlast)  len_nxt = '0;
        else if (wrap) len_nxt = '0;
        else           len_nxt = len_r + 10'd4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      pend_r    <= '0;
      len_r     <= '0;
      max_len_r <= b64e_pkg::MAX_LINE_RESET;
    end else begin
      pos_r  <= pos_nxt;
      pend_r <= pend_nxt;
      len_r  <= len_nxt;
      if (cfg_valid && cfg_ready) max_len_r <= cfg_data;
    end
  end

endmodule

// ===== rtl/b64e_queue.sv =====
// Small job queue between front and back ends.
// Depends on b64e_pkg for the job record.
module b64e_queue #(
  parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  b64e_pkg::job_t  push_job,
  input  logic            pop,
  output b64e_pkg::job_t  head_job,
  output logic            full,
  output logic            empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  b64e_pkg::job_t    mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push)
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== rtl/b64e_back.sv =====
// Back end: walks the head job one character per cycle into the output
// register while that register is free. Depends on b64e_pkg.
module b64e_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  b64e_pkg::job_t                q_head,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [b64e_pkg::CHAR_W-1:0]   out_tdata,
  output logic                          out_tlast,
  output logic                          out_tuser
);

  logic [b64e_pkg::IDX_W-1:0]   idx_r;
  logic                         out_tvalid_r;
  logic [b64e_pkg::CHAR_W-1:0]  out_tdata_r;
  logic                         out_tlast_r, out_tuser_r;
  logic                         slot_free, fire, last;

  assign slot_free = !out_tvalid_r || out_tready;
  assign fire      = slot_free && !q_empty;
  assign last      = (idx_r == (q_head.crlf ? b64e_pkg::LAST_CRLF : b64e_pkg::LAST_PLAIN));
  assign q_pop     = fire && last;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

  always_ff @(posedge clk) begin
    if (fire) begin
      out_tdata_r <= q_head.chars[idx_r];
      out_tlast_r <= last;
      out_tuser_r <= last && q_head.msg_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (fire) idx_r <= last ? '0 : idx_r + 1'b1;
      if (slot_free) out_tvalid_r <= fire;
    end
  end

endmodule

// ===== tb/sv/base64_encoder_line_wrap_test.sv =====
// Self-checking bench for base64_encoder_line_wrap: streams messages through the
// encoder under several line limits and checks every character against a
// local Base64 line-wrap predictor. Depends on b64e_pkg and the RTL top.
module base64_encoder_line_wrap_test;

  localparam logic [0:63][7:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int GAP_PCT = 12;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } msg_byte_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       msg_end;
  } b64_char_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;
  logic              out_tlast;
  logic              out_tuser;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [b64e_pkg::LINE_W-1:0] cfg_data = '0;

  msg_byte_t   send_bytes[$];
  b64_char_t   pending_chars[$];
  bit          calm = 1'b0;
  bit          limit_req = 1'b0;
  logic [b64e_pkg::LINE_W-1:0] limit_value = '0;
  int          mismatch_count = 0;

  // predictor state
  logic [1:0]        grp_pos = '0;
  logic [15:0]       held = '0;
  logic [b64e_pkg::LINE_W-1:0] line_cnt = '0;
  logic [b64e_pkg::LINE_W-1:0] wrap_limit = b64e_pkg::MAX_LINE_RESET;

  base64_encoder_line_wrap u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] data_byte
    .in_tlast   (in_tlast),   // final_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [7:0] out_char
    .out_tlast  (out_tlast),  // run_last
    .out_tuser  (out_tuser),  // [0] message_end
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] b64_symbol(input logic [5:0] six);
    return B64_ALPHABET[six];
  endfunction

  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    logic [7:0] chars [0:5];
    logic [7:0] c1;
    logic [7:0] c2;
    logic [1:0] pos;
    int         n;
    int         count;
    int         limit;
    b64_char_t  want;
    n = 0;
    pos = (grp_pos == 2'd3) ? 2'd0 : grp_pos;
    c1 = held[15:8];
    c2 = held[7:0];
    if (pos != 2'd2 && !fin) begin
      if (pos == 2'd0) held = {b, 8'h00};
      else held[7:0] = b;
      grp_pos = pos + 2'd1;
      return;
    end
    if (pos == 2'd0) begin
      chars[0] = b64_symbol(b[7:2]);
      chars[1] = b64_symbol({b[1:0], 4'b0000});
      chars[2] = b64e_pkg::CHAR_PAD;
      chars[3] = b64e_pkg::CHAR_PAD;
      n = 4;
      line_cnt = '0;
    end else if (pos == 2'd1) begin
      chars[0] = b64_symbol(c1[7:2]);
      chars[1] = b64_symbol({c1[1:0], b[7:4]});
      chars[2] = b64_symbol({b[3:0], 2'b00});
      chars[3] = b64e_pkg::CHAR_PAD;
      n = 4;
      line_cnt = '0;
    end else begin
      chars[0] = b64_symbol(c1[7:2]);
      chars[1] = b64_symbol({c1[1:0], c2[7:4]});
      chars[2] = b64_symbol({c2[3:0], b[7:6]});
      chars[3] = b64_symbol(b[5:0]);
      n = 4;
      count = int'(line_cnt) + 4;
      limit = int'(wrap_limit) - 4;
      if (count > limit) begin
        chars[4] = b64e_pkg::CHAR_CR;
        chars[5] = b64e_pkg::CHAR_LF;
        n = 6;
        count = 0;
      end
      line_cnt = fin ? '0 : count[b64e_pkg::LINE_W-1:0];
    end
    grp_pos = '0;
    held = '0;
    for (int i = 0; i < n; i++) begin
      want.ch = chars[i];
      want.run_last = (i == n - 1);
      want.msg_end = fin && (i == n - 1);
      pending_chars.push_back(want);
    end
  endfunction

  always @(posedge clk) begin : drive_p
    msg_byte_t tx;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= GAP_PCT);
      if (cfg_valid) begin
        if (cfg_ready) begin
          cfg_valid <= 1'b0;
          limit_req <= 1'b0;
        end
      end else if (limit_req) begin
        cfg_valid <= 1'b1;
        cfg_data <= limit_value;
      end
      if (!in_tvalid || in_tready) begin
        if (send_bytes.size() != 0 && (calm || $urandom_range(99) >= GAP_PCT)) begin
          tx = send_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= tx.data;
          in_tlast <= tx.fin;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_p
    b64_char_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_chars.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected char: got %h last=%b end=%b",
                     out_tdata, out_tlast, out_tuser);
        end else begin
          want = pending_chars.pop_front();
          if (out_tdata !== want.ch || out_tlast !== want.run_last ||
              out_tuser !== want.msg_end) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("char mismatch: exp %h last=%b end=%b, got %h last=%b end=%b",
                       want.ch, want.run_last, want.msg_end,
                       out_tdata, out_tlast, out_tuser);
          end
        end
      end
      if (cfg_valid && cfg_ready) wrap_limit = cfg_data;
      if (in_tvalid && in_tready) encode_byte(in_tdata, in_tlast);
    end
  end

  task automatic push_byte(input logic [7:0] d, input logic fin);
    msg_byte_t item;
    item.data = d;
    item.fin = fin;
    send_bytes.push_back(item);
  endtask

  task automatic queue_message(input int len, input bit terminate);
    for (int i = 0; i < len; i++)
      push_byte(8'($urandom_range(255)), terminate && (i == len - 1));
  endtask

  task automatic wait_drained();
    while (send_bytes.size() != 0 || in_tvalid || pending_chars.size() != 0)
      @(negedge clk);
  endtask

  // only touched while idle; trailing bytes may still sit in the group register
  task automatic set_limit(input logic [b64e_pkg::LINE_W-1:0] v);
    wait_drained();
    repeat (8) @(negedge clk);
    limit_value = v;
    limit_req = 1'b1;
    while (limit_req) @(negedge clk);
  endtask

  task automatic random_messages(input bit open_end);
    int n;
    int len;
    n = 0;
    while (n < 20) begin
      len = ($urandom_range(99) < 80) ? $urandom_range(12, 1) : $urandom_range(60, 13);
      queue_message(len, 1'b1);
      n += len;
    end
    if (open_end) queue_message($urandom_range(5, 1), 1'b0);
  endtask

  initial begin : stim_p
    logic [b64e_pkg::LINE_W-1:0] limits [0:10];
    limits = '{10'd1023, 10'd0, 10'd1, 10'd3, 10'd4, 10'd5, 10'd8, 10'd76,
               10'($urandom_range(40)), 10'($urandom_range(1023)), 10'd76};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset limit: single and double leftovers, full groups, final on a group
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b1);
    push_byte(8'h4D, 1'b0); push_byte(8'h61, 1'b0); push_byte(8'h6E, 1'b1);
    push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b1);

    // zero limit: CR LF after every full group, including a final one
    set_limit(10'd0);
    push_byte(8'h12, 1'b0); push_byte(8'h34, 1'b0); push_byte(8'h56, 1'b1);
    push_byte(8'h01, 1'b0); push_byte(8'h02, 1'b0); push_byte(8'h03, 1'b0);
    push_byte(8'h04, 1'b1);

    for (int k = 0; k < 11; k++) begin
      set_limit(limits[k]);
      calm = (k == 5);
      random_messages(k == 2 || k == 7);
    end

    wait_drained();
    repeat (16) @(negedge clk);
    if (mismatch_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin : watchdog_p
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
